>>> sv/assert_macros.svh
// Assertion macros shared by the serializer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/pis_pkg.sv
// Types, constants and codes shared by the panel init-sequence serializer.
package pis_pkg;

    localparam int FRAME_BITS  = 16;
    localparam int WORD_W      = 2 * FRAME_BITS;
    localparam int POS_W       = $clog2(WORD_W);
    localparam int FRAME_IDX_W = $clog2(FRAME_BITS);
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 16;
    localparam int VALUE_W     = 16;
    localparam int MS_W        = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    // Power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0] CODE_MASK     = 16'hFF00;
    localparam logic [CODE_W-1:0] CODE_SLEEP    = 16'h1000;
    localparam logic [CODE_W-1:0] CODE_END      = 16'h2000;
    localparam logic [BYTE_W-1:0] IDX_DATA_ONLY = 8'hFF;

    localparam logic [CFG_DATA_W-1:0] INDEX_PREFIX_RST = 8'h70;
    localparam logic [CFG_DATA_W-1:0] DATA_PREFIX_RST  = 8'h72;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_PREFIX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_PREFIX  = 8'd1;

    localparam logic [1:0] KIND_BIT   = 2'd0;
    localparam logic [1:0] KIND_SLEEP = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SLEEP = 2'd1,
        OP_DONE  = 2'd2
    } op_kind_t;

    // Decoded entry. For writes, word holds the frames in send order from the MSB;
    // a data-only entry has its single frame in the upper half.
    typedef struct packed {
        op_kind_t              kind;
        logic                  has_index;
        logic [WORD_W-1:0]     word;
        logic [MS_W-1:0]       sleep_ms;
    } op_t;

endpackage

>>> sv/pis_front.sv
// Front end: prefix registers, entry decode and frame word assembly.
module pis_front
    import pis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CODE_W-1:0]     s_entry_code,
    input  logic [VALUE_W-1:0]    s_entry_value,
    output logic                  op_valid,
    input  logic                  op_ready,
    output op_t                   op
);

    logic [CFG_DATA_W-1:0] index_prefix_reg, index_prefix_next;
    logic [CFG_DATA_W-1:0] data_prefix_reg, data_prefix_next;
    logic [BYTE_W-1:0]     idx;
    logic [BYTE_W-1:0]     data_byte;

    assign cfg_ready = 1'b1;

    always_comb begin
        index_prefix_next = index_prefix_reg;
        data_prefix_next  = data_prefix_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_INDEX_PREFIX: index_prefix_next = cfg_data;
                CFG_DATA_PREFIX:  data_prefix_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_prefix_reg <= INDEX_PREFIX_RST;
            data_prefix_reg  <= DATA_PREFIX_RST;
        end else begin
            index_prefix_reg <= index_prefix_next;
            data_prefix_reg  <= data_prefix_next;
        end
    end

    assign idx       = s_entry_code[BYTE_W-1:0];
    assign data_byte = s_entry_value[BYTE_W-1:0];

    always_comb begin
        op = '0;
        unique case (s_entry_code & CODE_MASK)
            CODE_END: begin
                op.kind = OP_DONE;
            end
            CODE_SLEEP: begin
                op.kind     = OP_SLEEP;
                op.sleep_ms = s_entry_value;
            end
            default: begin
                op.kind      = OP_WRITE;
                op.has_index = (idx != IDX_DATA_ONLY);
                if (idx != IDX_DATA_ONLY) begin
                    op.word = {index_prefix_reg, idx, data_prefix_reg, data_byte};
                end else begin
                    op.word = {data_prefix_reg, data_byte, {FRAME_BITS{1'b0}}};
                end
            end
        endcase
    end

    assign op_valid = s_valid;
    assign s_ready  = op_ready;

endmodule

>>> sv/pis_queue.sv
// Short queue of decoded entries between front and back ends.
module pis_queue
    import pis_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_op,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_op
);

`include "assert_macros.svh"

    op_t               entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entries_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    `ASSERT_ALWAYS(a_count_range, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_IMPLIES(a_ptr_gap, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue ptr mismatch")

endmodule

>>> sv/pis_back.sv
// Back end: walks the head entry one result per cycle into the output register, unless the receiver stalls it.
module pis_back
    import pis_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    output logic              head_pop,
    input  op_t               head_op,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_kind,
    output logic              m_bit_level,
    output logic              m_frame_first,
    output logic              m_frame_final,
    output logic [MS_W-1:0]   m_sleep_ms,
    output logic              m_last_of_run
);

`include "assert_macros.svh"

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic             level_reg, level_next;
    logic             first_reg, first_next;
    logic             final_reg, final_next;
    logic [MS_W-1:0]  ms_reg, ms_next;
    logic             last_reg, last_next;
    logic             load;

    assign load = head_valid && (!m_valid_reg || m_ready);

    always_comb begin
        kind_next  = KIND_BIT;
        level_next = 1'b0;
        first_next = 1'b0;
        final_next = 1'b0;
        ms_next    = '0;
        last_next  = 1'b0;
        unique case (head_op.kind)
            OP_DONE: begin
                kind_next = KIND_DONE;
                last_next = 1'b1;
            end
            OP_SLEEP: begin
                kind_next = KIND_SLEEP;
                ms_next   = head_op.sleep_ms;
                last_next = 1'b1;
            end
            OP_WRITE: begin
                level_next = head_op.word[~pos_reg];
                first_next = (pos_reg[FRAME_IDX_W-1:0] == '0);
                final_next = (pos_reg[FRAME_IDX_W-1:0] == '1);
                last_next  = final_next && (pos_reg[POS_W-1] || !head_op.has_index);
            end
            default: ;
        endcase
    end

    assign head_pop = load && last_next;

    always_comb begin
        pos_next = pos_reg;
        if (head_pop) begin
            pos_next = '0;
        end else if (load) begin
            pos_next = pos_reg + POS_W'(1);
        end
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            level_reg <= level_next;
            first_reg <= first_next;
            final_reg <= final_next;
            ms_reg    <= ms_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_bit_level   = level_reg;
    assign m_frame_first = first_reg;
    assign m_frame_final = final_reg;
    assign m_sleep_ms    = ms_reg;
    assign m_last_of_run = last_reg;

    `ASSERT_IMPLIES(a_mid_entry_head, pos_reg != '0, head_valid && head_op.kind == OP_WRITE, "bit position without write entry")
    `ASSERT_IMPLIES(a_last_bit_final, m_valid_reg && last_reg && kind_reg == KIND_BIT, final_reg, "run ends mid frame")
    `ASSERT_IMPLIES(a_ms_only_sleep, m_valid_reg && ms_reg != '0, kind_reg == KIND_SLEEP, "delay on non-sleep result")

endmodule

>>> sv/panel_init_sequence_serializer.sv
// Top level of the panel init-sequence serializer.
//
// Input channel s_*: one init-sequence entry per item (code word, value word).
// Output channel m_*: one result per item: a serial bit, a sleep request or done.
// Config channel cfg_*: index 0 writes the index-frame prefix, index 1 the
// data-frame prefix; other indexes are ignored. Always ready.
// An entry is decoded as it is accepted and placed in a two-entry queue; the
// back end walks the head entry and loads one result per cycle into the output
// register unless the receiver stalls it. The first result goes from the queue
// slot into the output register. Write entries give 32 results (16 when data
// only), sleep and end entries one; the output register loading one result per
// cycle sets the pace, and entries follow each other without gaps.
// A stalled receiver holds the output register; the queue keeps taking entries
// until both slots fill, then s_ready drops.
// Reset: prefixes return to 0x70 and 0x72, queue and output register empty.
module panel_init_sequence_serializer
    import pis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CODE_W-1:0]     s_entry_code,
    input  logic [VALUE_W-1:0]    s_entry_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic                  m_bit_level,
    output logic                  m_frame_first,
    output logic                  m_frame_final,
    output logic [MS_W-1:0]       m_sleep_ms,
    output logic                  m_last_of_run
);

    logic front_valid;
    logic front_ready;
    op_t  front_op;
    logic head_valid;
    logic head_pop;
    op_t  head_op;

    pis_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_code  (s_entry_code),
        .s_entry_value (s_entry_value),
        .op_valid      (front_valid),
        .op_ready      (front_ready),
        .op            (front_op)
    );

    pis_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_op     (head_op)
    );

    pis_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_pop      (head_pop),
        .head_op       (head_op),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_bit_level   (m_bit_level),
        .m_frame_first (m_frame_first),
        .m_frame_final (m_frame_final),
        .m_sleep_ms    (m_sleep_ms),
        .m_last_of_run (m_last_of_run)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the panel init-sequence serializer.
module tb
    import pis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int CYCLE_LIMIT    = 400_000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_GAP      = 8;
    localparam int PHASE_ITEMS    = 155;
    localparam int MAX_PRINTS     = 40;

    typedef struct packed {
        logic [1:0]      kind;
        logic            level;
        logic            frame_first;
        logic            frame_final;
        logic [MS_W-1:0] sleep_ms;
        logic            last_of_run;
    } serial_result_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [1:0]         kind;
        logic [MS_W-1:0]    sleep_ms;
    } entry_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CODE_W-1:0]     s_entry_code = '0;
    logic [VALUE_W-1:0]    s_entry_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_result_kind;
    logic                  m_bit_level;
    logic                  m_frame_first;
    logic                  m_frame_final;
    logic [MS_W-1:0]       m_sleep_ms;
    logic                  m_last_of_run;

    serial_result_t        pending_results[$];
    logic [CFG_DATA_W-1:0] index_prefix_q = INDEX_PREFIX_RST;
    logic [CFG_DATA_W-1:0] data_prefix_q  = DATA_PREFIX_RST;
    int unsigned           mismatches = 0;
    int unsigned           cycle_count = 0;
    int unsigned           tx_idle_pct = 0;
    int unsigned           rx_idle_pct = 0;
    int unsigned           rx_hold_req = 0;
    int unsigned           rx_hold_seen = 0;
    int unsigned           rx_hold_left = 0;

    entry_row_t directed_rows [15] = '{
        '{CODE_END,                  16'h0000, 1'b1, KIND_DONE,  16'h0000},
        '{CODE_END | 16'h00FF,       16'hFFFF, 1'b1, KIND_DONE,  16'h0000},
        '{CODE_SLEEP,                16'h0000, 1'b1, KIND_SLEEP, 16'h0000},
        '{CODE_SLEEP | 16'h00FF,     16'hFFFF, 1'b1, KIND_SLEEP, 16'hFFFF},
        '{CODE_SLEEP | 16'h0034,     16'h8001, 1'b1, KIND_SLEEP, 16'h8001},
        '{16'h0000,                  16'h0000, 1'b0, KIND_BIT,   16'h0000},
        '{16'hFFFE,                  16'hFFFF, 1'b0, KIND_BIT,   16'h0000},
        '{{8'h00, IDX_DATA_ONLY},    16'h00A5, 1'b0, KIND_BIT,   16'h0000},
        '{{8'hFF, IDX_DATA_ONLY},    16'hFF5A, 1'b0, KIND_BIT,   16'h0000},
        '{16'h1100,                  16'h3C81, 1'b0, KIND_BIT,   16'h0000},
        '{16'h3055,                  16'h1234, 1'b0, KIND_BIT,   16'h0000},
        '{16'h2101,                  16'hC3FE, 1'b0, KIND_BIT,   16'h0000},
        '{CODE_END | 16'h00AB,       16'h5555, 1'b1, KIND_DONE,  16'h0000},
        '{16'h1F80,                  16'hAA01, 1'b0, KIND_BIT,   16'h0000},
        '{16'h0001,                  16'h0080, 1'b0, KIND_BIT,   16'h0000}
    };

    panel_init_sequence_serializer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_code  (s_entry_code),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_bit_level   (m_bit_level),
        .m_frame_first (m_frame_first),
        .m_frame_final (m_frame_final),
        .m_sleep_ms    (m_sleep_ms),
        .m_last_of_run (m_last_of_run)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [MS_W-1:0] got,
                               input logic [MS_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic push_frame(input logic [FRAME_BITS-1:0] word, input logic closes_run);
        serial_result_t r;
        for (int b = FRAME_BITS - 1; b >= 0; b--) begin
            r.kind        = KIND_BIT;
            r.level       = word[b];
            r.frame_first = (b == FRAME_BITS - 1);
            r.frame_final = (b == 0);
            r.sleep_ms    = '0;
            r.last_of_run = closes_run && (b == 0);
            pending_results.push_back(r);
        end
    endtask

    // Expected results of one accepted entry under the current prefixes.
    task automatic serialize_entry(input logic [CODE_W-1:0] code,
                                   input logic [VALUE_W-1:0] value);
        logic [CODE_W-1:0] marker;
        marker = code & CODE_MASK;
        if (marker == CODE_END) begin
            pending_results.push_back('{KIND_DONE, 1'b0, 1'b0, 1'b0, '0, 1'b1});
        end else if (marker == CODE_SLEEP) begin
            pending_results.push_back('{KIND_SLEEP, 1'b0, 1'b0, 1'b0, value, 1'b1});
        end else begin
            if (code[BYTE_W-1:0] != IDX_DATA_ONLY)
                push_frame({index_prefix_q, code[BYTE_W-1:0]}, 1'b0);
            push_frame({data_prefix_q, value[BYTE_W-1:0]}, 1'b1);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req != rx_hold_seen) begin
            m_ready      <= 1'b0;
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        serial_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, kind %0d", m_result_kind));
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", m_result_kind, want.kind);
                check_field("bit_level",   m_bit_level,   want.level);
                check_field("frame_first", m_frame_first, want.frame_first);
                check_field("frame_final", m_frame_final, want.frame_final);
                check_field("sleep_ms",    m_sleep_ms,    want.sleep_ms);
                check_field("last_of_run", m_last_of_run, want.last_of_run);
            end
        end
    end

    task automatic offer_entry(input logic [CODE_W-1:0] code,
                               input logic [VALUE_W-1:0] value);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_entry_code  <= code;
        s_entry_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // Prefix writes with an ignored out-of-range index in between.
    task automatic write_prefixes(input logic [CFG_DATA_W-1:0] idx_pfx,
                                  input logic [CFG_DATA_W-1:0] dat_pfx);
        logic [CFG_IDX_W-1:0]  idx_list [3];
        logic [CFG_DATA_W-1:0] data_list [3];
        idx_list[0]  = CFG_INDEX_PREFIX;
        data_list[0] = idx_pfx;
        idx_list[1]  = CFG_DATA_PREFIX + 8'($urandom_range(1, 254));
        data_list[1] = 8'($urandom);
        idx_list[2]  = CFG_DATA_PREFIX;
        data_list[2] = dat_pfx;
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= data_list[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx_list[i])
                CFG_INDEX_PREFIX: index_prefix_q = data_list[i];
                CFG_DATA_PREFIX:  data_prefix_q  = data_list[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                    input int hold_at, input int pause_at);
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        int unsigned        pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == hold_at)
                rx_hold_req <= rx_hold_req + 1;
            if (n == pause_at)
                wait_drained();
            pick  = $urandom_range(99);
            value = 16'($urandom);
            code  = 16'($urandom);
            if (pick < 10)
                code = CODE_SLEEP | {8'h00, code[BYTE_W-1:0]};
            else if (pick < 17)
                code = CODE_END | {8'h00, code[BYTE_W-1:0]};
            else if (pick < 35)
                code = {code[CODE_W-1:BYTE_W], IDX_DATA_ONLY};
            offer_entry(code, value);
            serialize_entry(code, value);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct <= 52;
        foreach (directed_rows[i]) begin
            offer_entry(directed_rows[i].code, directed_rows[i].value);
            if (directed_rows[i].typed)
                pending_results.push_back('{directed_rows[i].kind, 1'b0, 1'b0, 1'b0,
                                            directed_rows[i].sleep_ms, 1'b1});
            else
                serialize_entry(directed_rows[i].code, directed_rows[i].value);
        end
        wait_drained();

        write_prefixes(8'hFF, 8'h00);
        run_random_phase(20, 52, 40, -1);
        wait_drained();

        write_prefixes(8'h00, 8'hFF);
        run_random_phase(52, 20, -1, 80);
        wait_drained();

        write_prefixes(8'($urandom), 8'($urandom));
        run_random_phase(0, 0, -1, -1);
        wait_drained();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
